/* rtl/core/touch_press_release_detector_core_assert.svh */
// Assertion macros for the touch press/release detector core.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef TOUCH_PRESS_RELEASE_DETECTOR_CORE_ASSERT_SVH
`define TOUCH_PRESS_RELEASE_DETECTOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/tpr_pkg.sv */
// Shared constants and types for the touch press/release detector.
// No dependencies; used by the interfaces, the pad lane and the top level.
`timescale 1ns / 1ps

package tpr_pkg;

  // Field widths
  localparam int PAD_W       = 10;
  localparam int CNT_W       = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 10;

  // Default pad count
  localparam int NUM_PADS_DEF = 10;

  // Register reset values
  localparam logic [PAD_W-1:0] PAD_ENABLE_RESET = '0;
  localparam logic [CNT_W-1:0] HOLD_TICKS_RESET = 8'd10;
  localparam logic [CNT_W-1:0] HOLD_TICKS_MIN   = 8'd1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_ENABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS = 1'b1;

  // Item kinds
  localparam logic MODE_SAMPLE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Per-pad control broadcast from the top level to every lane
  typedef struct packed {
    logic             load;    // matched sample accepted this cycle
    logic             dec;     // tick accepted while the timer runs
    logic [CNT_W-1:0] reload;  // countdown reload value
  } lane_ctrl_t;

  // Per-pad status returned to the top level
  typedef struct packed {
    logic press;    // new press on this word
    logic expire;   // countdown reaches zero on this word
    logic busy;     // countdown nonzero
    logic holding;  // countdown stays nonzero after a tick
  } lane_stat_t;

endpackage

/* rtl/core/tpr_if.sv */
// Valid/ready channel interfaces for the touch press/release detector.
// Depends on tpr_pkg for field widths.
`timescale 1ns / 1ps

interface tpr_in_if;
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic [tpr_pkg::PAD_W-1:0]  pad_status;

  modport source (output valid, mode, pad_status, input ready);
  modport sink   (input valid, mode, pad_status, output ready);
endinterface

interface tpr_out_if;
  logic                       valid;
  logic                       ready;
  logic [tpr_pkg::PAD_W-1:0]  press_mask;
  logic [tpr_pkg::PAD_W-1:0]  release_mask;
  logic                       timer_running;
  logic                       all_released;

  modport source (output valid, press_mask, release_mask, timer_running, all_released,
                  input ready);
  modport sink   (input valid, press_mask, release_mask, timer_running, all_released,
                  output ready);
endinterface

/* rtl/core/touch_press_release_detector_core.sv */
// Touch press/release detector: debounced press detection with per-pad release timeout.
// Each result word is loaded into the output register when its input is taken.
// Throughput: one word per cycle, sample or tick, while the output side takes results.
// Each pad's countdown and compare is one lane of parallel logic before the result register.
// Reset (synchronous, rst_n low): countdowns and last sample zero, timer stopped, all released,
// pad enables cleared, hold time 10 ticks, output register empty.
`timescale 1ns / 1ps
`include "touch_press_release_detector_core_assert.svh"

module touch_press_release_detector_core #(
  parameter int NUM_PADS = tpr_pkg::NUM_PADS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tpr_in_if.sink                          in_if,
  tpr_out_if.source                       out_if,
  input  logic                            cfg_we,
  input  logic [tpr_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [tpr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int PAD_W = tpr_pkg::PAD_W;
  localparam int CNT_W = tpr_pkg::CNT_W;

  // Configuration registers
  logic [PAD_W-1:0] pad_enable_r;
  logic [CNT_W-1:0] hold_ticks_r;

  // Detector state
  logic [PAD_W-1:0] prev_status_r, prev_status_nxt;
  logic             released_r, released_nxt;
  logic             ticking_r, ticking_nxt;

  // Output register
  logic             out_valid_r;
  logic [PAD_W-1:0] press_r, press_nxt;
  logic [PAD_W-1:0] release_r, release_nxt;
  logic             running_r;
  logic             all_rel_r;

  logic                in_fire;
  logic                sample_match;
  logic                tick_live;
  logic                any_holding;
  logic                any_busy;
  tpr_pkg::lane_ctrl_t lane_ctrl;

  logic [NUM_PADS-1:0] lane_touch;
  logic [NUM_PADS-1:0] lane_press;
  logic [NUM_PADS-1:0] lane_expire;
  logic [NUM_PADS-1:0] lane_busy;
  logic [NUM_PADS-1:0] lane_holding;

  // Accept whenever the output register is free or draining this cycle
  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  // Classify the incoming word
  assign sample_match = in_fire && (in_if.mode == tpr_pkg::MODE_SAMPLE)
                        && (in_if.pad_status == prev_status_r);
  assign tick_live    = in_fire && (in_if.mode == tpr_pkg::MODE_TICK) && ticking_r;

  always_comb begin
    lane_ctrl.load   = sample_match;
    lane_ctrl.dec    = tick_live;
    lane_ctrl.reload = (hold_ticks_r == '0) ? tpr_pkg::HOLD_TICKS_MIN : hold_ticks_r;
  end

  // Pad lanes
  for (genvar i = 0; i < NUM_PADS; i++) begin : g_lane
    tpr_pkg::lane_stat_t stat;

    if (i < PAD_W) begin : g_touch
      assign lane_touch[i] = in_if.pad_status[i] && pad_enable_r[i];
    end else begin : g_no_touch
      assign lane_touch[i] = 1'b0;
    end

    tpr_pad_lane u_lane (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (lane_ctrl),
      .touch (lane_touch[i]),
      .stat  (stat)
    );

    assign lane_press[i]   = stat.press;
    assign lane_expire[i]  = stat.expire;
    assign lane_busy[i]    = stat.busy;
    assign lane_holding[i] = stat.holding;
  end

  assign any_holding = |lane_holding;
  assign any_busy    = |lane_busy;

  // Fold lane flags onto the fixed-width result masks
  for (genvar j = 0; j < PAD_W; j++) begin : g_mask
    if (j < NUM_PADS) begin : g_pad
      assign press_nxt[j]   = lane_press[j];
      assign release_nxt[j] = lane_expire[j];
    end else begin : g_none
      assign press_nxt[j]   = 1'b0;
      assign release_nxt[j] = 1'b0;
    end
  end

  // Next detector state
  always_comb begin
    prev_status_nxt = prev_status_r;
    released_nxt    = released_r;
    ticking_nxt     = ticking_r;
    if (in_fire && (in_if.mode == tpr_pkg::MODE_SAMPLE) && !sample_match) begin
      prev_status_nxt = in_if.pad_status;
    end
    if (sample_match && released_r) begin
      released_nxt = 1'b0;
      ticking_nxt  = 1'b1;
    end
    if (tick_live && !any_holding) begin
      released_nxt = 1'b1;
      ticking_nxt  = 1'b0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad_enable_r <= tpr_pkg::PAD_ENABLE_RESET;
      hold_ticks_r <= tpr_pkg::HOLD_TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tpr_pkg::CFG_PAD_ENABLE: pad_enable_r <= cfg_wdata[PAD_W-1:0];
        tpr_pkg::CFG_HOLD_TICKS: hold_ticks_r <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Detector state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_status_r <= '0;
      released_r    <= 1'b1;
      ticking_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      prev_status_r <= prev_status_nxt;
      released_r    <= released_nxt;
      ticking_r     <= ticking_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold otherwise
  always_ff @(posedge clk) begin
    if (in_fire) begin
      press_r   <= press_nxt;
      release_r <= release_nxt;
      running_r <= ticking_nxt;
      all_rel_r <= released_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.press_mask    = press_r;
  assign out_if.release_mask  = release_r;
  assign out_if.timer_running = running_r;
  assign out_if.all_released  = all_rel_r;

  // Checks
  `TPR_ASSERT_NOW(a_flags_exclusive, 1'b1, ticking_r != released_r, "timer and released overlap")
  `TPR_ASSERT_NOW(a_released_idle, released_r, !any_busy, "countdown active while all released")
  `TPR_ASSERT_NOW(a_masks_disjoint, out_valid_r, !((|press_r) && (|release_r)), "masks overlap")
  `TPR_ASSERT_NEXT(a_stop_clears, tick_live && !any_holding, !any_busy, "countdown after stop")

endmodule

/* rtl/core/tpr_pad_lane.sv */
// One pad's release countdown: reload on a matched touch, count down on ticks.
// Depends on tpr_pkg for lane_ctrl_t, lane_stat_t and CNT_W.
`timescale 1ns / 1ps

module tpr_pad_lane (
  input  logic                clk,
  input  logic                rst_n,
  input  tpr_pkg::lane_ctrl_t ctrl,
  input  logic                touch,
  output tpr_pkg::lane_stat_t stat
);

  logic [tpr_pkg::CNT_W-1:0] cnt_r;
  logic [tpr_pkg::CNT_W-1:0] cnt_nxt;
  logic                      busy;

  assign busy = (cnt_r != '0);

  // Report busy, holding, press and expire from the current count
  always_comb begin
    stat.busy    = busy;
    stat.holding = (cnt_r > tpr_pkg::CNT_W'(1));
    stat.press   = ctrl.load && touch && !busy;
    stat.expire  = ctrl.dec && (cnt_r == tpr_pkg::CNT_W'(1));
  end

  // Reload on touch, otherwise count down while nonzero
  always_comb begin
    cnt_nxt = cnt_r;
    if (ctrl.load && touch) begin
      cnt_nxt = ctrl.reload;
    end else if (ctrl.dec && busy) begin
      cnt_nxt = cnt_r - tpr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule
